// ----- hdl/vmc_pkg.sv -----
// Shared types and constants for the vending machine controller.
package vmc_pkg;

    // Request actions.
    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_SELECT = 2'd1,
        ACT_END    = 2'd2,
        ACT_COIN   = 2'd3
    } action_t;

    // Operating phases.
    typedef enum logic [1:0] {
        PH_LOAD   = 2'd0,
        PH_SELECT = 2'd1,
        PH_PAY    = 2'd2
    } phase_t;

    // Result status codes.
    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_ADVANCED   = 4'd1;
    localparam logic [3:0] ST_WRONG_PH   = 4'd2;
    localparam logic [3:0] ST_NO_OP      = 4'd3;
    localparam logic [3:0] ST_BAD_SLOT   = 4'd4;
    localparam logic [3:0] ST_OCCUPIED   = 4'd5;
    localparam logic [3:0] ST_EMPTY      = 4'd6;
    localparam logic [3:0] ST_MISMATCH   = 4'd7;
    localparam logic [3:0] ST_BAD_QTY    = 4'd8;
    localparam logic [3:0] ST_BAD_COIN   = 4'd9;
    localparam logic [3:0] ST_PAID       = 4'd10;

    // Coin values accepted from the customer.
    localparam logic [3:0] COIN_ONE  = 4'd1;
    localparam logic [3:0] COIN_TWO  = 4'd2;
    localparam logic [3:0] COIN_FIVE = 4'd5;

    // Change coin codes.
    localparam logic [2:0] CHG_NONE = 3'd0;
    localparam logic [2:0] CHG_ONE  = 3'd1;
    localparam logic [2:0] CHG_TWO  = 3'd2;
    localparam logic [2:0] CHG_FIVE = 3'd5;

    localparam logic [5:0]  MAX_STOCK  = 6'd50;
    localparam logic [3:0]  MAX_PRICE  = 4'd9;
    localparam logic [4:0]  MAX_LETTER = 5'd25;
    localparam logic [12:0] DUE_MAX    = 13'd8191;

    typedef struct packed {
        logic [1:0] action;
        logic [2:0] slot;
        logic [4:0] item_code;
        logic [3:0] price;
        logic [5:0] quantity;
        logic [3:0] coin;
    } vmc_req_t;

    typedef struct packed {
        logic [3:0] status;
        logic [2:0] change_coin;
        logic       last;
    } vmc_res_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;
        logic commit;
    } vmc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic res_empty;
    } vmc_stat_t;

endpackage

// ----- hdl/vmc_ctrl.sv -----
// Controller state machine: request capture and execute sequencing.
module vmc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  vmc_pkg::vmc_stat_t stat,
    output vmc_pkg::vmc_cmd_t  cmd
);
    import vmc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd.load_req = 1'b0;
        cmd.commit   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // Results of the previous request must be gone before this one lands.
                if (stat.res_empty)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_EXEC))
        else $error("accepted request did not move to execute");
    a_commit_needs_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (stat.res_empty && state_reg == S_EXEC))
        else $error("commit while results still pending");
`endif

endmodule

// ----- hdl/vmc_datapath.sv -----
// Datapath: request register, slot table, amount due and result queue.
module vmc_datapath #(
    parameter int NUM_SLOTS = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  vmc_pkg::vmc_req_t  in_data,
    input  vmc_pkg::vmc_cmd_t  cmd,
    output vmc_pkg::vmc_stat_t stat,
    output logic               out_valid,
    input  logic               out_ready,
    output vmc_pkg::vmc_res_t  out_data
);
    import vmc_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [4:0] SLOT_LIM = 5'(NUM_SLOTS);

    vmc_req_t    req_reg;

    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic        did_op_reg;
    logic        did_op_next;
    logic [12:0] due_reg;
    logic [12:0] due_next;

    logic        slot_used_reg  [NUM_SLOTS];
    logic [4:0]  slot_item_reg  [NUM_SLOTS];
    logic [3:0]  slot_price_reg [NUM_SLOTS];
    logic [5:0]  slot_stock_reg [NUM_SLOTS];

    vmc_res_t    res_reg [2];
    logic [1:0]  cnt_reg;

    // Combinational results of the request held in req_reg.
    vmc_res_t    r0;
    vmc_res_t    r1;
    logic [1:0]  n_res;
    logic        slot_wr;
    logic        wr_used;
    logic [4:0]  wr_item;
    logic [3:0]  wr_price;
    logic [5:0]  wr_stock;

    logic [3:0]  slot_m1;
    logic [IDX_W-1:0] idx;
    logic        slot_ok;
    logic        cur_used;
    logic [4:0]  cur_item;
    logic [3:0]  cur_price;
    logic [5:0]  cur_stock;
    logic [9:0]  product;
    logic [13:0] due_sum;
    logic [5:0]  stock_left;
    logic        coin_ok;
    logic [13:0] diff;
    logic [13:0] neg_diff;
    logic [2:0]  back;
    logic [2:0]  chg1;
    logic [2:0]  rem;
    logic        pop;

    assign slot_m1   = 4'({1'b0, req_reg.slot}) - 4'd1;
    assign idx       = IDX_W'(slot_m1);
    assign slot_ok   = (req_reg.slot != 3'd0) && ({2'b00, req_reg.slot} <= SLOT_LIM);
    assign cur_used  = slot_used_reg[idx];
    assign cur_item  = slot_item_reg[idx];
    assign cur_price = slot_price_reg[idx];
    assign cur_stock = slot_stock_reg[idx];

    assign product    = 10'(cur_price) * 10'(req_reg.quantity);
    assign due_sum    = {1'b0, due_reg} + 14'(product);
    assign stock_left = cur_stock - req_reg.quantity;
    assign coin_ok    = (req_reg.coin == COIN_ONE) || (req_reg.coin == COIN_TWO)
                     || (req_reg.coin == COIN_FIVE);
    assign diff       = coin_ok ? ({1'b0, due_reg} - 14'(req_reg.coin)) : {1'b0, due_reg};
    assign neg_diff   = 14'd0 - diff;
    assign back       = neg_diff[2:0];

    // Greedy change: at most two coins, since the overshoot never exceeds four
    // unless it is exactly a five.
    always_comb
    begin
        if (back >= 3'd5)
        begin
            chg1 = CHG_FIVE;
        end
        else if (back >= 3'd2)
        begin
            chg1 = CHG_TWO;
        end
        else
        begin
            chg1 = CHG_ONE;
        end
    end
    assign rem = back - chg1;

    always_comb
    begin
        r0          = '{status: ST_OK, change_coin: CHG_NONE, last: 1'b1};
        r1          = '{status: ST_PAID, change_coin: CHG_NONE, last: 1'b1};
        n_res       = 2'd1;
        phase_next  = phase_reg;
        did_op_next = did_op_reg;
        due_next    = due_reg;
        slot_wr     = 1'b0;
        wr_used     = cur_used;
        wr_item     = cur_item;
        wr_price    = cur_price;
        wr_stock    = cur_stock;
        case (req_reg.action)
            ACT_LOAD:
            begin
                if (phase_reg != PH_LOAD)
                    r0.status = ST_WRONG_PH;
                else if (req_reg.item_code > MAX_LETTER)
                    r0.status = ST_MISMATCH;
                else if (!slot_ok)
                    r0.status = ST_BAD_SLOT;
                else if (cur_used)
                    r0.status = ST_OCCUPIED;
                else if (req_reg.price > MAX_PRICE || req_reg.quantity == 6'd0
                         || req_reg.quantity > MAX_STOCK)
                    r0.status = ST_BAD_QTY;
                else
                begin
                    slot_wr     = 1'b1;
                    wr_used     = 1'b1;
                    wr_item     = req_reg.item_code;
                    wr_price    = req_reg.price;
                    wr_stock    = req_reg.quantity;
                    did_op_next = 1'b1;
                end
            end
            ACT_SELECT:
            begin
                if (phase_reg != PH_SELECT)
                    r0.status = ST_WRONG_PH;
                else if (req_reg.item_code > MAX_LETTER)
                    r0.status = ST_MISMATCH;
                else if (!slot_ok)
                    r0.status = ST_BAD_SLOT;
                else if (!cur_used)
                    r0.status = ST_EMPTY;
                else if (cur_item != req_reg.item_code)
                    r0.status = ST_MISMATCH;
                else if (req_reg.quantity == 6'd0 || req_reg.quantity > cur_stock)
                    r0.status = ST_BAD_QTY;
                else
                begin
                    due_next    = due_sum[13] ? DUE_MAX : due_sum[12:0];
                    slot_wr     = 1'b1;
                    wr_stock    = stock_left;
                    did_op_next = 1'b1;
                    if (stock_left == 6'd0)
                    begin
                        wr_used  = 1'b0;
                        wr_item  = 5'd0;
                        wr_price = 4'd0;
                    end
                end
            end
            ACT_END:
            begin
                if (phase_reg == PH_PAY)
                    r0.status = ST_WRONG_PH;
                else if (!did_op_reg)
                    r0.status = ST_NO_OP;
                else
                begin
                    phase_next  = (phase_reg == PH_LOAD) ? PH_SELECT : PH_PAY;
                    did_op_next = 1'b0;
                    r0.status   = ST_ADVANCED;
                end
            end
            default:
            begin
                if (phase_reg != PH_PAY)
                    r0.status = ST_WRONG_PH;
                else if (!coin_ok && due_reg != 13'd0)
                    r0.status = ST_BAD_COIN;
                else if (!diff[13] && diff != 14'd0)
                begin
                    // Still owing after a good coin.
                    due_next    = diff[12:0];
                    did_op_next = 1'b1;
                end
                else
                begin
                    due_next    = 13'd0;
                    did_op_next = 1'b0;
                    phase_next  = PH_SELECT;
                    if (!coin_ok)
                    begin
                        // A bad coin with nothing due still closes the sale.
                        r0    = '{status: ST_BAD_COIN, change_coin: CHG_NONE, last: 1'b0};
                        n_res = 2'd2;
                    end
                    else if (back == 3'd0)
                    begin
                        r0.status = ST_PAID;
                    end
                    else
                    begin
                        r0 = '{status: ST_PAID, change_coin: chg1, last: (rem == 3'd0)};
                        if (rem != 3'd0)
                        begin
                            r1.change_coin = (rem >= 3'd2) ? CHG_TWO : CHG_ONE;
                            n_res          = 2'd2;
                        end
                    end
                end
            end
        endcase
    end

    assign pop            = out_valid && out_ready;
    assign out_valid      = (cnt_reg != 2'd0);
    assign out_data       = res_reg[0];
    assign stat.res_empty = (cnt_reg == 2'd0);

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= in_data;
        end
        if (cmd.commit)
        begin
            res_reg[0] <= r0;
            res_reg[1] <= r1;
        end
        else if (pop)
        begin
            res_reg[0] <= res_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && slot_wr)
        begin
            slot_item_reg[idx]  <= wr_item;
            slot_price_reg[idx] <= wr_price;
            slot_stock_reg[idx] <= wr_stock;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_LOAD;
            did_op_reg <= 1'b0;
            due_reg    <= 13'd0;
            cnt_reg    <= 2'd0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_used_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cmd.commit)
            begin
                phase_reg  <= phase_next;
                did_op_reg <= did_op_next;
                due_reg    <= due_next;
                cnt_reg    <= n_res;
                if (slot_wr)
                begin
                    slot_used_reg[idx] <= wr_used;
                end
            end
            else if (pop)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2)
        else $error("result queue overfilled");
    a_load_no_due: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LOAD) |-> (due_reg == 13'd0))
        else $error("amount due while still loading");
    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("illegal phase value");
`endif

endmodule

// ----- hdl/vending_machine_controller.sv -----
// Vending machine controller: top level joining controller and datapath.
//
// Requests enter on in_valid/in_ready with an in_data struct (action, slot,
// item_code, price, quantity, coin). Results leave on out_valid/out_ready with
// an out_data struct (status, change_coin, last); each request gives one or
// two results, the final one marked by last.
// A request is captured when accepted and executed once the result queue is
// empty; the two-state controller takes no new request until it has executed.
// The first result is offered the cycle after execution.
// Results sit in a two-entry queue. A new request is accepted while results
// wait there, but its execution holds until the queue has drained, so a
// stalled receiver stops the block after one buffered request.
// Reset clears the phase to loading, the amount due and operation flag to
// zero, marks every slot empty and empties the result queue; the block is
// ready for a request in the first cycle after reset.
module vending_machine_controller #(
    parameter int NUM_SLOTS = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  vmc_pkg::vmc_req_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output vmc_pkg::vmc_res_t out_data
);
    import vmc_pkg::*;

    vmc_cmd_t  cmd;
    vmc_stat_t stat;

    vmc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    vmc_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
